// File: rtl/fdnr_pkg.sv
// Shared types, constants and helpers for the feedback delay network reverb.
// Holds the item structs, controller state and command/status bundles.
// No dependencies.
package fdnr_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int LINE_COUNT  = 4;
  localparam int LINE_W      = 2;
  localparam int DIV_STEPS   = 25;
  localparam int CNT_W       = 5;
  localparam int LEN_REG_W   = 13;
  localparam int MIN_LEN     = 8;

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_FEEDBACK   = 3'd0,
    REG_DAMP_ALPHA = 3'd1,
    REG_SIDE_GAIN  = 3'd2,
    REG_LEN_A      = 3'd3,
    REG_LEN_B      = 3'd4,
    REG_LEN_C      = 3'd5,
    REG_LEN_D      = 3'd6
  } reg_e;

  localparam logic [15:0] RST_FEEDBACK   = 16'd47186;
  localparam logic [15:0] RST_DAMP_ALPHA = 16'd3991;
  localparam logic [15:0] RST_SIDE_GAIN  = 16'd4915;
  localparam logic [12:0] RST_LEN_A      = 13'd1781;
  localparam logic [12:0] RST_LEN_B      = 13'd2098;
  localparam logic [12:0] RST_LEN_C      = 13'd2558;
  localparam logic [12:0] RST_LEN_D      = 13'd2933;

  // Fixed-point constants: 0.22, 0.55*0.22, 0.20*0.22, 0.42
  localparam logic signed [15:0] C_INJ_MID    = 16'sd14418;
  localparam logic signed [30:0] C_INJ_WIDE   = 31'sd519696810;
  localparam logic signed [30:0] C_INJ_NARROW = 31'sd188976726;
  localparam logic signed [15:0] C_TAP        = 16'sd27525;
  // 27.0 and 3.0 in Q.24 for the rational tanh
  localparam logic [30:0] K27_Q24 = 31'd452984832;
  localparam logic [28:0] K3_Q24  = 29'd50331648;

  // Hadamard rows, a set bit means subtract that line
  localparam logic [3:0] HSIGN_NEG [LINE_COUNT] = '{4'b0000, 4'b1010, 4'b1100, 4'b0110};

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] wet_left;
    logic signed [SAMPLE_BITS-1:0] wet_right;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DAMP_MUL,
    ST_DAMP_UPD,
    ST_PRE,
    ST_FB_MUL,
    ST_ACC,
    ST_SQ,
    ST_NUM,
    ST_DINIT,
    ST_DIV,
    ST_WRITE,
    ST_TAP,
    ST_SIDE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              clr_wr;
    logic              load_in;
    logic              rd;
    logic              damp_mul;
    logic              damp_upd;
    logic              pre;
    logic              fb_mul;
    logic              acc;
    logic              sq;
    logic              num;
    logic              dinit;
    logic              div_step;
    logic              wr;
    logic              tap;
    logic              side;
    logic              out_load;
    logic [LINE_W-1:0] line;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_full;
  } stat_t;

  // Clamp to the sample range
  function automatic sample_t sat_sample(input logic signed [31:0] v);
    sample_t r;
    if (v > 32'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -32'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/feedback_delay_network_reverb.sv
// Four-line feedback delay network reverb, one stereo pair in and one wet
// pair out per item. After reset the block sweeps its delay memories to zero
// and takes no item meanwhile (register writes work). An item is taken only
// while the sequencer is idle: the block works one item through to its
// result in the output register before it takes the next, and each of the
// four lines passes in turn through the shared bit-serial divider of the
// tanh soft clip. The output register holds a finished result while the next
// item is already being taken. Registers sit on the APB-style port at byte
// address 4*i: feedback gain, damping alpha, side gain, then the four line
// lengths (clamped to 8..LINE_DEPTH).
// Depends on fdnr_pkg, fdnr_ctrl and fdnr_dpath.
module feedback_delay_network_reverb #(
  parameter int LINE_DEPTH = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fdnr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fdnr_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import fdnr_pkg::*;

  localparam int LEN_W = $clog2(LINE_DEPTH + 1);
  localparam int CMP_W = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(LINE_DEPTH);
  localparam logic [CMP_W-1:0] MIN_C   = CMP_W'(MIN_LEN);

  logic [15:0]          fb_q, alpha_q, sg_q;
  logic [LEN_REG_W-1:0] len_q [LINE_COUNT];
  logic [LEN_W-1:0]     len_eff [LINE_COUNT];
  logic                 wr_en;
  reg_e                 widx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign widx   = reg_e'(paddr[4:2]);

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q     <= RST_FEEDBACK;
      alpha_q  <= RST_DAMP_ALPHA;
      sg_q     <= RST_SIDE_GAIN;
      len_q[0] <= RST_LEN_A;
      len_q[1] <= RST_LEN_B;
      len_q[2] <= RST_LEN_C;
      len_q[3] <= RST_LEN_D;
    end else if (wr_en) begin
      unique case (widx)
        REG_FEEDBACK:   fb_q     <= pwdata[15:0];
        REG_DAMP_ALPHA: alpha_q  <= pwdata[15:0];
        REG_SIDE_GAIN:  sg_q     <= pwdata[15:0];
        REG_LEN_A:      len_q[0] <= pwdata[LEN_REG_W-1:0];
        REG_LEN_B:      len_q[1] <= pwdata[LEN_REG_W-1:0];
        REG_LEN_C:      len_q[2] <= pwdata[LEN_REG_W-1:0];
        REG_LEN_D:      len_q[3] <= pwdata[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (widx)
      REG_FEEDBACK:   prdata = 32'(fb_q);
      REG_DAMP_ALPHA: prdata = 32'(alpha_q);
      REG_SIDE_GAIN:  prdata = 32'(sg_q);
      REG_LEN_A:      prdata = 32'(len_q[0]);
      REG_LEN_B:      prdata = 32'(len_q[1]);
      REG_LEN_C:      prdata = 32'(len_q[2]);
      REG_LEN_D:      prdata = 32'(len_q[3]);
      default:        prdata = '0;
    endcase
  end

  // Clamp line lengths to the usable range
  always_comb begin
    for (int i = 0; i < LINE_COUNT; i++) begin
      if (CMP_W'(len_q[i]) < MIN_C) begin
        len_eff[i] = LEN_W'(MIN_C);
      end else if (CMP_W'(len_q[i]) > DEPTH_C) begin
        len_eff[i] = LEN_W'(DEPTH_C);
      end else begin
        len_eff[i] = LEN_W'(len_q[i]);
      end
    end
  end

  cmd_t  cmd;
  stat_t stat;

  fdnr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fdnr_dpath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .fb_i        (fb_q),
    .alpha_i     (alpha_q),
    .sg_i        (sg_q),
    .len_i       (len_eff),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/fdnr_ctrl.sv
// Sequencer for the reverb: steps the datapath through one item at a time.
// Depends on fdnr_pkg.
module fdnr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  fdnr_pkg::stat_t stat_i,
  output fdnr_pkg::cmd_t  cmd_o
);
  import fdnr_pkg::*;

  state_e            state_q, state_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      line_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      line_q  <= line_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    line_d     = line_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.line = line_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        line_d   = '0;
        state_d  = ST_DAMP_MUL;
      end
      ST_DAMP_MUL: begin
        cmd_o.damp_mul = 1'b1;
        state_d        = ST_DAMP_UPD;
      end
      ST_DAMP_UPD: begin
        cmd_o.damp_upd = 1'b1;
        line_d         = line_q + 1'b1;
        state_d        = (line_q == LINE_W'(LINE_COUNT - 1)) ? ST_PRE : ST_DAMP_MUL;
      end
      ST_PRE: begin
        cmd_o.pre = 1'b1;
        state_d   = ST_FB_MUL;
      end
      ST_FB_MUL: begin
        cmd_o.fb_mul = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = ST_NUM;
      end
      ST_NUM: begin
        cmd_o.num = 1'b1;
        state_d   = ST_DINIT;
      end
      ST_DINIT: begin
        cmd_o.dinit = 1'b1;
        cnt_d       = '0;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.wr = 1'b1;
        line_d   = line_q + 1'b1;
        state_d  = (line_q == LINE_W'(LINE_COUNT - 1)) ? ST_TAP : ST_FB_MUL;
      end
      ST_TAP: begin
        cmd_o.tap = 1'b1;
        state_d   = ST_SIDE;
      end
      ST_SIDE: begin
        cmd_o.side = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the item
        if (!stat_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/fdnr_dpath.sv
// Datapath for the reverb: delay memories, damping, mixing, rational tanh
// with a bit-serial divider, output taps and the output register. Uses fdnr_pkg.
module fdnr_dpath #(
  parameter int LINE_DEPTH = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fdnr_pkg::cmd_t       cmd_i,
  output fdnr_pkg::stat_t      stat_o,
  input  fdnr_pkg::in_item_t   in_data_i,
  input  logic [15:0]          fb_i,
  input  logic [15:0]          alpha_i,
  input  logic [15:0]          sg_i,
  input  logic [$clog2(LINE_DEPTH+1)-1:0] len_i [fdnr_pkg::LINE_COUNT],
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fdnr_pkg::out_item_t  out_data_o
);
  import fdnr_pkg::*;

  localparam int PW    = $clog2(LINE_DEPTH);
  localparam int LEN_W = $clog2(LINE_DEPTH + 1);

  in_item_t        in_q;
  logic [PW-1:0]   clr_addr_q;
  logic [PW-1:0]   pos_q   [LINE_COUNT];
  logic [PW-1:0]   pos_eff [LINE_COUNT];
  sample_t         rd_q    [LINE_COUNT];
  sample_t         damp_q  [LINE_COUNT];
  logic [PW-1:0]   waddr   [LINE_COUNT];
  logic            we      [LINE_COUNT];
  sample_t         wv;

  logic signed [41:0] dprod_q;
  logic signed [39:0] p_mid_q;
  logic signed [54:0] p_wide_q, p_nar_q;
  logic signed [42:0] fprod_q;
  logic [28:0]        mag_q;
  logic               neg_q, sat_q;
  logic [27:0]        x2_q;
  logic [55:0]        num_q;
  logic [30:0]        den_q;
  logic [30:0]        rem_q;
  logic [24:0]        low_q, quo_q;
  logic signed [40:0] mid_q, tap_q;
  logic signed [57:0] side_q;
  out_item_t          out_q;
  logic               out_valid_q;

  // Clear sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  assign stat_o.clr_done = (clr_addr_q == PW'(LINE_DEPTH - 1));
  assign stat_o.out_full = out_valid_q && out_stall_i;

  // Delay lines: one memory per line
  for (genvar g = 0; g < LINE_COUNT; g++) begin : g_line
    logic [SAMPLE_BITS-1:0] mem [LINE_DEPTH];
    logic [LEN_W-1:0]       nxt;

    assign pos_eff[g] = (LEN_W'(pos_q[g]) >= len_i[g]) ? '0 : pos_q[g];
    assign we[g]      = cmd_i.clr_wr || (cmd_i.wr && (cmd_i.line == LINE_W'(g)));
    assign waddr[g]   = cmd_i.clr_wr ? clr_addr_q : pos_q[g];
    assign nxt        = LEN_W'(pos_q[g]) + 1'b1;

    always_ff @(posedge clk_i) begin
      if (we[g]) mem[waddr[g]] <= cmd_i.clr_wr ? '0 : wv;
      if (cmd_i.rd) rd_q[g] <= mem[pos_eff[g]];
    end

    // Line position: pulled in on read, advanced after write-back
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pos_q[g] <= '0;
      end else if (cmd_i.rd) begin
        pos_q[g] <= pos_eff[g];
      end else if (cmd_i.wr && (cmd_i.line == LINE_W'(g))) begin
        pos_q[g] <= (nxt >= len_i[g]) ? '0 : PW'(nxt);
      end
    end
  end

  // Damping lowpass, one line per pass
  logic signed [24:0] ddiff;
  logic signed [16:0] alpha_s;
  logic signed [25:0] dstep;
  logic signed [26:0] dsum;
  assign ddiff   = 25'(rd_q[cmd_i.line]) - 25'(damp_q[cmd_i.line]);
  assign alpha_s = $signed({1'b0, alpha_i});
  assign dstep   = 26'((dprod_q + 42'sd32768) >>> 16);
  assign dsum    = 27'(damp_q[cmd_i.line]) + 27'(dstep);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damp_q <= '{default: '0};
    end else if (cmd_i.damp_upd) begin
      damp_q[cmd_i.line] <= sat_sample(32'(dsum));
    end
  end

  // Hadamard row sum for the current line
  logic signed [25:0] msum;
  always_comb begin
    msum = '0;
    for (int j = 0; j < LINE_COUNT; j++) begin
      if (HSIGN_NEG[cmd_i.line][j]) msum = msum - 26'(damp_q[j]);
      else                          msum = msum + 26'(damp_q[j]);
    end
  end

  // Input injection terms
  logic signed [24:0] m2, s2;
  assign m2 = 25'(in_q.in_left) + 25'(in_q.in_right);
  assign s2 = 25'(in_q.in_left) - 25'(in_q.in_right);

  // Feedback sum and tanh argument
  logic signed [16:0] fb_s;
  logic signed [55:0] side_t;
  logic signed [39:0] side_r;
  logic signed [44:0] mid_t, acc;
  logic signed [28:0] xarg;
  assign fb_s = $signed({1'b0, fb_i});
  always_comb begin
    case (cmd_i.line)
      2'd0:    side_t = 56'(p_wide_q);
      2'd1:    side_t = 56'(p_nar_q);
      2'd2:    side_t = -56'(p_nar_q);
      default: side_t = -56'(p_wide_q);
    endcase
  end
  assign side_r = 40'((side_t + 56'sd32768) >>> 16);
  assign mid_t  = cmd_i.line[0] ? -45'(p_mid_q) : 45'(p_mid_q);
  assign acc    = mid_t + 45'(side_r) + 45'(fprod_q);
  assign xarg   = 29'((acc + 45'sd32768) >>> 16);

  // Rational tanh terms
  logic [25:0] m26;
  logic [51:0] sqp;
  logic [29:0] kterm;
  logic [55:0] dvd;
  logic [31:0] trial;
  assign m26   = mag_q[25:0];
  assign sqp   = 52'(m26) * 52'(m26);
  assign kterm = 30'(K27_Q24) + 30'(x2_q);
  assign dvd   = num_q + 56'(den_q >> 1);
  assign trial = {rem_q, low_q[24]};

  // Write-back value
  logic [24:0] yv;
  logic [24:0] ohalf;
  logic [23:0] ocap;
  assign yv    = sat_q ? 25'h1000000 : quo_q;
  assign ohalf = 25'((26'(yv) + 26'd1) >> 1);
  assign ocap  = (ohalf > 25'h7FFFFF) ? 24'h7FFFFF : ohalf[23:0];
  assign wv    = neg_q ? -$signed(ocap) : $signed(ocap);

  // Output mix
  logic signed [24:0] d03, d21;
  logic signed [16:0] sg_s;
  logic signed [43:0] side_v;
  logic signed [45:0] sl, sr;
  logic signed [29:0] wl, wr;
  assign d03    = 25'(rd_q[0]) - 25'(rd_q[3]);
  assign d21    = 25'(rd_q[2]) - 25'(rd_q[1]);
  assign sg_s   = $signed({1'b0, sg_i});
  assign side_v = 44'((side_q + 58'sd8192) >>> 14);
  assign sl     = 46'(mid_q) + 46'(side_v);
  assign sr     = 46'(mid_q) - 46'(side_v);
  assign wl     = 30'((sl + 46'sd32768) >>> 16);
  assign wr     = 30'((sr + 46'sd32768) >>> 16);

  // Arithmetic pipeline registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_data_i;
    if (cmd_i.damp_mul) dprod_q <= 42'(ddiff) * 42'(alpha_s);
    if (cmd_i.pre) begin
      p_mid_q  <= 40'(m2) * 40'(C_INJ_MID);
      p_wide_q <= 55'(s2) * 55'(C_INJ_WIDE);
      p_nar_q  <= 55'(s2) * 55'(C_INJ_NARROW);
    end
    if (cmd_i.fb_mul) fprod_q <= 43'(msum) * 43'(fb_s);
    if (cmd_i.acc) begin
      neg_q <= xarg[28];
      mag_q <= xarg[28] ? 29'(-xarg) : 29'(xarg);
      sat_q <= (xarg[28] ? 29'(-xarg) : 29'(xarg)) >= K3_Q24;
    end
    if (cmd_i.sq) x2_q <= sqp[51:24];
    if (cmd_i.num) begin
      num_q <= 56'(m26) * 56'(kterm);
      den_q <= K27_Q24 + 31'({x2_q, 3'b000}) + 31'(x2_q);
    end
    // restoring divider, one quotient bit a step
    if (cmd_i.dinit) begin
      rem_q <= dvd[55:25];
      low_q <= dvd[24:0];
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      low_q <= {low_q[23:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_q <= 31'(trial - {1'b0, den_q});
        quo_q <= {quo_q[23:0], 1'b1};
      end else begin
        rem_q <= trial[30:0];
        quo_q <= {quo_q[23:0], 1'b0};
      end
    end
    if (cmd_i.tap) begin
      mid_q <= 41'(d03) * 41'(C_TAP);
      tap_q <= 41'(d21) * 41'(C_TAP);
    end
    if (cmd_i.side) side_q <= 58'(tap_q) * 58'(sg_s);
    if (cmd_i.out_load) begin
      out_q.wet_left  <= sat_sample(32'(wl));
      out_q.wet_right <= sat_sample(32'(wr));
    end
  end

  // Output register handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
